### sv/pxhp_pkg.sv
// Shared types, character codes, status codes and keyword tables of the proxy header parser.
// No dependencies; every other file refers to it by scoped names.
package pxhp_pkg;

	localparam int LINE_MAX_BYTES_DEF = 107;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [1:0] ST_HANDSHAKE = 2'd0;
	localparam logic [1:0] ST_OK        = 2'd1;
	localparam logic [1:0] ST_FAILED    = 2'd2;
	localparam logic [1:0] ST_NONE      = 2'd3;

	localparam logic [16:0] NUM_SAT    = 17'h1FFFF;
	localparam logic [16:0] OCTET_MAX  = 17'd255;
	localparam logic [16:0] PORT_MAX   = 17'd65535;

	localparam int OUT_TDATA_W = 104;

	// Byte as seen by the back end: raw value plus the tests it needs most.
	typedef struct packed {
		logic [7:0] raw;
		logic       is_digit;
		logic [3:0] digit;
		logic       is_cr;
		logic       is_lf;
		logic       is_dot;
		logic       is_space;
		logic       is_u;
		logic       is_t;
	} byte_class_t;

	// "PROXY "
	function automatic logic [7:0] lit_proxy(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h50;
			3'd1: c = 8'h52;
			3'd2: c = 8'h4F;
			3'd3: c = 8'h58;
			3'd4: c = 8'h59;
			3'd5: c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "UNKNOWN"
	function automatic logic [7:0] lit_unknown(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h55;
			3'd1: c = 8'h4E;
			3'd2: c = 8'h4B;
			3'd3: c = 8'h4E;
			3'd4: c = 8'h4F;
			3'd5: c = 8'h57;
			3'd6: c = 8'h4E;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "TCP4 "
	function automatic logic [7:0] lit_tcp4(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h54;
			3'd1: c = 8'h43;
			3'd2: c = 8'h50;
			3'd3: c = 8'h34;
			3'd4: c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### sv/proxy_v1_header_parser_unit.sv
// Top level of the text proxy header (version 1) parser.
// Depends on pxhp_pkg, pxhp_classify, pxhp_queue and pxhp_engine.
//
// One byte of the connection enters per transfer on the s_ side and gives
// exactly one result transfer on the m_ side. Unless m_tready holds results back,
// the block sustains one byte per clock: the front end classifies the byte and
// writes it into a two-entry queue in the same cycle, and the back end takes one
// queued byte per cycle through its line state machine into the result register.
// A byte's result goes through a queue entry and the result register. The result
// reports whether the byte belonged to the header line (consumed), the line
// status (0 in handshake, 1 ok, 2 failed, 3 none), and, once a TCP4 line ends
// ok, the protocol, both IPv4 addresses and both ports; these fields read
// zero otherwise. Numbers are checked for leading zeros and for limits of 255
// (address octets) and 65535 (ports). A line that reaches LINE_MAX_BYTES - 1
// bytes without a CR fails. Write cfg_wdata = 1 to expect a header line (the
// reset value) or 0 to pass every byte through with status none; a write
// restarts the parser and must only happen while the block is idle.
module proxy_v1_header_parser_unit #(
	parameter int LINE_MAX_BYTES = pxhp_pkg::LINE_MAX_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration: expect_handshake
	input  logic                               cfg_wen,
	input  logic                               cfg_wdata,
	// input bytes
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,  // [7:0] data_byte
	// results
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] consumed, [2:1] status, [3] protocol, [35:4] source_address,
	// [67:36] dest_address, [83:68] source_port, [99:84] dest_port, [103:100] zero
	output logic [pxhp_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	pxhp_pkg::byte_class_t in_cls;
	pxhp_pkg::byte_class_t head;
	logic                  q_full;
	logic                  q_not_empty;
	logic                  pop;
	logic                  push;

	// accept a byte whenever the queue has room
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	pxhp_classify u_classify (
		.data_in (s_tdata),
		.cls     (in_cls)
	);

	pxhp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (in_cls),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	pxhp_engine #(
		.LINE_MAX_BYTES (LINE_MAX_BYTES)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.item_valid (q_not_empty),
		.item       (head),
		.item_pop   (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

endmodule

### sv/pxhp_classify.sv
// Front end of the proxy header parser: tags each incoming byte with its character class.
// Depends on pxhp_pkg.
module pxhp_classify (
	input  logic [7:0]           data_in,
	output pxhp_pkg::byte_class_t cls
);

	always_comb begin
		cls.raw      = data_in;
		cls.is_digit = (data_in >= pxhp_pkg::CH_ZERO) && (data_in <= pxhp_pkg::CH_NINE);
		cls.digit    = 4'(data_in - pxhp_pkg::CH_ZERO);
		cls.is_cr    = (data_in == pxhp_pkg::CH_CR);
		cls.is_lf    = (data_in == pxhp_pkg::CH_LF);
		cls.is_dot   = (data_in == pxhp_pkg::CH_DOT);
		cls.is_space = (data_in == pxhp_pkg::CH_SPACE);
		cls.is_u     = (data_in == pxhp_pkg::CH_U);
		cls.is_t     = (data_in == pxhp_pkg::CH_T);
	end

endmodule

### sv/pxhp_queue.sv
// Two-entry queue of classified bytes between front and back end.
// Depends on pxhp_pkg.
module pxhp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pxhp_pkg::byte_class_t push_item,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output pxhp_pkg::byte_class_t head
);

	pxhp_pkg::byte_class_t entry_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/pxhp_engine.sv
// Back end of the proxy header parser: line state machine, number checks and result register.
// Depends on pxhp_pkg.
module pxhp_engine #(
	parameter int LINE_MAX_BYTES = pxhp_pkg::LINE_MAX_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic                                cfg_wdata,
	input  logic                                item_valid,
	input  pxhp_pkg::byte_class_t               item,
	output logic                                item_pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pxhp_pkg::OUT_TDATA_W-1:0]    out_data
);

	localparam int LEN_W = $clog2(LINE_MAX_BYTES);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_MAX_BYTES - 1);

	typedef enum logic [3:0] {
		PH_PROXY, PH_KIND, PH_UNKNOWN, PH_TCP4, PH_ANY, PH_SRC, PH_DST,
		PH_SPORT, PH_DPORT, PH_BAD, PH_DONE_UNK, PH_DONE_TCP4
	} phase_t;

	phase_t           phase_q, n_phase;
	logic [2:0]       lit_q, n_lit;
	logic [LEN_W-1:0] len_q, n_len;
	logic             cr_q, n_cr;
	logic [1:0]       outcome_q, n_outcome;
	logic [16:0]      num_q, n_num;
	logic             dig_q, n_dig;
	logic             lz_q, n_lz;
	logic [31:0]      src_q, n_src;
	logic [31:0]      dst_q, n_dst;
	logic [15:0]      sport_q, n_sport;
	logic [15:0]      dport_q, n_dport;
	logic [1:0]       oct_q, n_oct;
	logic             consumed;

	logic             out_valid_q;
	logic [pxhp_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic             is_addr;
	logic             lim_ok;
	logic             term_ok;
	logic [20:0]      num_ext;
	logic [16:0]      num_sat;
	logic             ok_tcp;

	assign item_pop  = item_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign is_addr = (phase_q == PH_SRC) || (phase_q == PH_DST);
	assign lim_ok  = dig_q && (is_addr ? (num_q <= pxhp_pkg::OCTET_MAX)
	                                   : (num_q <= pxhp_pkg::PORT_MAX));
	assign term_ok = (is_addr && oct_q != 2'd3) ? item.is_dot : item.is_space;
	// times ten as two shifts, then add the digit
	assign num_ext = {num_q, 3'b000} + {2'b00, num_q, 1'b0} + {17'd0, item.digit};
	assign num_sat = (num_ext > {4'd0, pxhp_pkg::NUM_SAT}) ? pxhp_pkg::NUM_SAT : num_ext[16:0];

	always_comb begin
		n_phase   = phase_q;
		n_lit     = lit_q;
		n_len     = len_q;
		n_cr      = cr_q;
		n_outcome = outcome_q;
		n_num     = num_q;
		n_dig     = dig_q;
		n_lz      = lz_q;
		n_src     = src_q;
		n_dst     = dst_q;
		n_sport   = sport_q;
		n_dport   = dport_q;
		n_oct     = oct_q;
		consumed  = 1'b0;

		if (outcome_q == pxhp_pkg::ST_HANDSHAKE) begin
			if (!cr_q) begin
				if (len_q >= LEN_LIMIT) begin
					n_outcome = pxhp_pkg::ST_FAILED;
				end else begin
					consumed = 1'b1;
					n_len    = len_q + 1'b1;
					if (item.is_cr) begin
						n_cr = 1'b1;
						if (phase_q == PH_ANY) begin
							n_phase = PH_DONE_UNK;
						end else if (phase_q == PH_DPORT && dig_q
						             && num_q <= pxhp_pkg::PORT_MAX) begin
							n_dport = num_q[15:0];
							n_phase = PH_DONE_TCP4;
						end else begin
							n_phase = PH_BAD;
						end
					end else if (item.is_lf) begin
						n_outcome = pxhp_pkg::ST_FAILED;
					end else begin
						case (phase_q)
							PH_PROXY: begin
								if (lit_q > 3'd5 || item.raw != pxhp_pkg::lit_proxy(lit_q)) begin
									n_phase = PH_BAD;
								end else if (lit_q == 3'd5) begin
									n_phase = PH_KIND;
									n_lit   = 3'd0;
								end else begin
									n_lit = lit_q + 3'd1;
								end
							end
							PH_KIND: begin
								if (item.is_u)      n_phase = PH_UNKNOWN;
								else if (item.is_t) n_phase = PH_TCP4;
								else                n_phase = PH_BAD;
								n_lit = 3'd1;
							end
							PH_UNKNOWN: begin
								if (lit_q > 3'd6 || item.raw != pxhp_pkg::lit_unknown(lit_q)) begin
									n_phase = PH_BAD;
								end else if (lit_q == 3'd6) begin
									n_phase = PH_ANY;
									n_lit   = 3'd0;
								end else begin
									n_lit = lit_q + 3'd1;
								end
							end
							PH_TCP4: begin
								if (lit_q > 3'd4 || item.raw != pxhp_pkg::lit_tcp4(lit_q)) begin
									n_phase = PH_BAD;
								end else if (lit_q == 3'd4) begin
									n_phase = PH_SRC;
									n_lit   = 3'd0;
									n_oct   = 2'd0;
									n_num   = 17'd0;
									n_dig   = 1'b0;
									n_lz    = 1'b0;
								end else begin
									n_lit = lit_q + 3'd1;
								end
							end
							PH_SRC, PH_DST, PH_SPORT, PH_DPORT: begin
								if (item.is_digit) begin
									if (dig_q && lz_q) begin
										// leading zero followed by another digit
										n_phase = PH_BAD;
									end else begin
										if (!dig_q) begin
											n_dig = 1'b1;
											n_lz  = (item.digit == 4'd0);
										end
										n_num = num_sat;
									end
								end else if (phase_q == PH_DPORT || !lim_ok || !term_ok) begin
									n_phase = PH_BAD;
								end else begin
									if (phase_q == PH_SRC) begin
										n_src = {src_q[23:0], num_q[7:0]};
									end else if (phase_q == PH_DST) begin
										n_dst = {dst_q[23:0], num_q[7:0]};
									end else begin
										n_sport = num_q[15:0];
									end
									if (is_addr) begin
										if (oct_q != 2'd3) begin
											n_oct = oct_q + 2'd1;
										end else begin
											n_oct   = 2'd0;
											n_phase = (phase_q == PH_SRC) ? PH_DST : PH_SPORT;
										end
									end else begin
										n_phase = PH_DPORT;
									end
									n_num = 17'd0;
									n_dig = 1'b0;
									n_lz  = 1'b0;
								end
							end
							PH_ANY: begin
								n_phase = PH_ANY;
							end
							default: begin
								n_phase = PH_BAD;
							end
						endcase
					end
				end
			end else if (item.is_lf) begin
				consumed  = 1'b1;
				n_outcome = (phase_q == PH_DONE_UNK || phase_q == PH_DONE_TCP4)
				            ? pxhp_pkg::ST_OK : pxhp_pkg::ST_FAILED;
			end else begin
				n_outcome = pxhp_pkg::ST_FAILED;
			end
		end
	end

	assign ok_tcp = (n_outcome == pxhp_pkg::ST_OK) && (n_phase == PH_DONE_TCP4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PROXY;
			lit_q       <= 3'd0;
			len_q       <= '0;
			cr_q        <= 1'b0;
			outcome_q   <= pxhp_pkg::ST_HANDSHAKE;
			num_q       <= 17'd0;
			dig_q       <= 1'b0;
			lz_q        <= 1'b0;
			src_q       <= 32'd0;
			dst_q       <= 32'd0;
			sport_q     <= 16'd0;
			dport_q     <= 16'd0;
			oct_q       <= 2'd0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (cfg_wen) begin
			// restart the parser; expect a header line only when the bit is set
			phase_q   <= PH_PROXY;
			lit_q     <= 3'd0;
			len_q     <= '0;
			cr_q      <= 1'b0;
			outcome_q <= cfg_wdata ? pxhp_pkg::ST_HANDSHAKE : pxhp_pkg::ST_NONE;
			num_q     <= 17'd0;
			dig_q     <= 1'b0;
			lz_q      <= 1'b0;
			src_q     <= 32'd0;
			dst_q     <= 32'd0;
			sport_q   <= 16'd0;
			dport_q   <= 16'd0;
			oct_q     <= 2'd0;
		end else begin
			if (out_valid_q && out_ready && !item_pop) begin
				out_valid_q <= 1'b0;
			end
			if (item_pop) begin
				phase_q     <= n_phase;
				lit_q       <= n_lit;
				len_q       <= n_len;
				cr_q        <= n_cr;
				outcome_q   <= n_outcome;
				num_q       <= n_num;
				dig_q       <= n_dig;
				lz_q        <= n_lz;
				src_q       <= n_src;
				dst_q       <= n_dst;
				sport_q     <= n_sport;
				dport_q     <= n_dport;
				oct_q       <= n_oct;
				out_valid_q <= 1'b1;
				out_data_q  <= {4'd0,
				                ok_tcp ? n_dport : 16'd0,
				                ok_tcp ? n_sport : 16'd0,
				                ok_tcp ? n_dst   : 32'd0,
				                ok_tcp ? n_src   : 32'd0,
				                ok_tcp,
				                n_outcome,
				                consumed};
			end
		end
	end

endmodule
